// ----- hdl/rotary_knob_bcd_entry_assert.svh -----
// assertion macros for the knob entry block
`ifndef ROTARY_KNOB_BCD_ENTRY_ASSERT_SVH
`define ROTARY_KNOB_BCD_ENTRY_ASSERT_SVH

`ifndef ASSERT_OFF
`define RKBE_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("rkbe assertion failed");
`define RKBE_ASSERT_NEXT(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("rkbe assertion failed");
`else
`define RKBE_ASSERT(name, prop)
`define RKBE_ASSERT_NEXT(name, cond, prop)
`endif

`endif

// ----- hdl/rkbe_pkg.sv -----
package rkbe_pkg;

  localparam logic [3:0]  MAX_DIGIT        = 4'd9;
  localparam logic [1:0]  WHOLE_POS        = 2'd3;
  localparam logic [15:0] LONG_PRESS_RESET = 16'd3000;
  localparam logic [15:0] TIMER_MAX        = 16'hFFFF;

  typedef struct packed {
    logic pin_a;
    logic pin_b;
    logic switch_level;
  } in_item_t;

  typedef struct packed {
    logic [3:0] hundreds;
    logic [3:0] tens;
    logic [3:0] ones;
    logic [1:0] edit_position;
    logic       changed;
  } out_item_t;

  typedef struct packed {
    logic [3:0] hundreds;
    logic [3:0] tens;
    logic [3:0] ones;
  } bcd_t;

  // press tracker results for one sample
  typedef struct packed {
    logic pressed;
    logic reset_done;
    logic advance;
    logic clear;
    logic release_seen;
  } press_ctl_t;

  function automatic logic [3:0] digit_step(input logic [3:0] d, input logic up);
    logic [3:0] r;
    if (up) begin
      r = (d >= MAX_DIGIT) ? 4'd0 : d + 4'd1;
    end else begin
      r = (d == 4'd0) ? MAX_DIGIT : d - 4'd1;
    end
    return r;
  endfunction

endpackage

// ----- hdl/rkbe_bcd_step.sv -----
module rkbe_bcd_step (
  input  logic             step_en,
  input  logic             up,
  input  logic [1:0]       cursor,
  input  rkbe_pkg::bcd_t   digits,
  output rkbe_pkg::bcd_t   digits_nxt
);

  logic ones_wrap;
  logic tens_wrap;

  // digit rolls over to its neighbour in the stepping direction
  assign ones_wrap = up ? (digits.ones == rkbe_pkg::MAX_DIGIT) : (digits.ones == 4'd0);
  assign tens_wrap = up ? (digits.tens == rkbe_pkg::MAX_DIGIT) : (digits.tens == 4'd0);

  always_comb begin
    digits_nxt = digits;
    if (step_en) begin
      unique case (cursor)
        2'd0: digits_nxt.hundreds = rkbe_pkg::digit_step(digits.hundreds, up);
        2'd1: digits_nxt.tens     = rkbe_pkg::digit_step(digits.tens, up);
        2'd2: digits_nxt.ones     = rkbe_pkg::digit_step(digits.ones, up);
        default: begin
          // whole value with decimal carry, wraps between 0 and 999
          digits_nxt.ones = rkbe_pkg::digit_step(digits.ones, up);
          if (ones_wrap) begin
            digits_nxt.tens = rkbe_pkg::digit_step(digits.tens, up);
          end
          if (ones_wrap && tens_wrap) begin
            digits_nxt.hundreds = rkbe_pkg::digit_step(digits.hundreds, up);
          end
        end
      endcase
    end
  end

endmodule

// ----- hdl/rkbe_press.sv -----
module rkbe_press (
  input  logic                 switch_level,
  input  logic                 last_switch,
  input  logic                 pressed,
  input  logic                 reset_done,
  input  logic [15:0]          press_timer,
  input  logic [15:0]          long_press_ticks,
  output logic [15:0]          press_timer_nxt,
  output rkbe_pkg::press_ctl_t ctl
);

  logic        sw_edge;
  logic        release_seen;
  logic        start;
  logic        pressed_mid;
  logic        reset_done_mid;
  logic [15:0] timer_inc;
  logic        clear;

  assign timer_inc = (pressed && press_timer != rkbe_pkg::TIMER_MAX) ?
                     press_timer + 16'd1 : press_timer;

  assign sw_edge      = switch_level != last_switch;
  assign release_seen = sw_edge && switch_level && pressed;
  // any other edge while not held starts a press
  assign start        = sw_edge && !pressed;

  assign pressed_mid     = release_seen ? 1'b0 : (start ? 1'b1 : pressed);
  assign reset_done_mid  = release_seen ? 1'b0 : reset_done;
  assign press_timer_nxt = start ? 16'd0 : timer_inc;

  assign clear = !reset_done_mid && pressed_mid && (press_timer_nxt >= long_press_ticks);

  always_comb begin
    ctl.pressed      = pressed_mid;
    ctl.reset_done   = reset_done_mid || clear;
    ctl.advance      = release_seen && !reset_done;
    ctl.clear        = clear;
    ctl.release_seen = release_seen;
  end

endmodule

// ----- hdl/rotary_knob_bcd_entry.sv -----
// a result passes through the input register, then the result register;
// throughput: one item per cycle while out_stall is low, set by the single
// registered next-state pass over the knob state
// reset (rst_n low, synchronous): digits 000, edit position 3, no press,
// long press threshold 3000, both stages empty
`include "rotary_knob_bcd_entry_assert.svh"

module rotary_knob_bcd_entry (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rkbe_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rkbe_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata
);

  logic                in_valid_r;
  rkbe_pkg::in_item_t  in_q_r;
  logic                out_valid_r;
  rkbe_pkg::out_item_t out_q_r;
  logic [15:0]         ticks_r;

  rkbe_pkg::bcd_t      digits_r;
  rkbe_pkg::bcd_t      digits_nxt;
  rkbe_pkg::bcd_t      digits_rot;
  logic [1:0]          cursor_r;
  logic [1:0]          cursor_nxt;
  logic                last_a_r;
  logic                last_switch_r;
  logic                pressed_r;
  logic                reset_done_r;
  logic [15:0]         timer_r;
  logic [15:0]         timer_nxt;

  rkbe_pkg::press_ctl_t ctl;
  rkbe_pkg::out_item_t  out_nxt;
  logic                 adv;
  logic                 accept;
  logic                 rotate;

  assign adv      = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !adv;
  assign accept   = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_q_r;

  // a detent only counts while the switch is not held
  assign rotate = (in_q_r.pin_a != last_a_r) && !pressed_r;

  rkbe_bcd_step u_bcd_step (
    .step_en    (rotate),
    .up         (in_q_r.pin_b != in_q_r.pin_a),
    .cursor     (cursor_r),
    .digits     (digits_r),
    .digits_nxt (digits_rot)
  );

  rkbe_press u_press (
    .switch_level     (in_q_r.switch_level),
    .last_switch      (last_switch_r),
    .pressed          (pressed_r),
    .reset_done       (reset_done_r),
    .press_timer      (timer_r),
    .long_press_ticks (ticks_r),
    .press_timer_nxt  (timer_nxt),
    .ctl              (ctl)
  );

  always_comb begin
    digits_nxt = ctl.clear ? '0 : digits_rot;
    cursor_nxt = ctl.advance ? cursor_r + 2'd1 : cursor_r;
    out_nxt.hundreds      = digits_nxt.hundreds;
    out_nxt.tens          = digits_nxt.tens;
    out_nxt.ones          = digits_nxt.ones;
    out_nxt.edit_position = cursor_nxt;
    out_nxt.changed       = rotate || ctl.release_seen || ctl.clear;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      ticks_r       <= rkbe_pkg::LONG_PRESS_RESET;
      digits_r      <= '0;
      cursor_r      <= rkbe_pkg::WHOLE_POS;
      last_a_r      <= 1'b0;
      last_switch_r <= 1'b1;
      pressed_r     <= 1'b0;
      reset_done_r  <= 1'b0;
      timer_r       <= 16'd0;
    end else begin
      if (cfg_we) begin
        ticks_r <= cfg_wdata;
      end
      if (accept) begin
        in_valid_r <= 1'b1;
      end else if (adv) begin
        in_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (adv) begin
        digits_r      <= digits_nxt;
        cursor_r      <= cursor_nxt;
        last_a_r      <= in_q_r.pin_a;
        last_switch_r <= in_q_r.switch_level;
        pressed_r     <= ctl.pressed;
        reset_done_r  <= ctl.reset_done;
        timer_r       <= timer_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_q_r <= in_data;
    end
    if (adv) begin
      out_q_r <= out_nxt;
    end
  end

  `RKBE_ASSERT(a_digits_bcd, digits_r.hundreds <= rkbe_pkg::MAX_DIGIT &&
               digits_r.tens <= rkbe_pkg::MAX_DIGIT && digits_r.ones <= rkbe_pkg::MAX_DIGIT)
  `RKBE_ASSERT(a_clear_only_held, !reset_done_r || pressed_r)
  `RKBE_ASSERT_NEXT(a_transfer_fills_out, adv, out_valid_r)

endmodule
